// ===== design/vpa_pkg.sv =====
// Shared constants and codes for the variable partition allocator.
// No dependencies; imported by the allocator, its checker and the bench.
`default_nettype none
package vpa_pkg;

  localparam int AW = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_TOTAL  = 2'd1;
  localparam logic [1:0] CFG_SLICE  = 2'd2;

  localparam logic [AW-1:0] TOTAL_RESET = 16'd1024;
  localparam logic [AW-1:0] SLICE_RESET = 16'd10;

endpackage
`default_nettype wire

// ===== design/vpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the free table and the owner table.
`default_nettype none
module vpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/variable_partition_allocator.sv =====
// Variable partition allocator: top level with sequencer, tables and output register.
// Depends on vpa_pkg and vpa_ram.
//
//  channel  | dir | tdata (low bit up)                 | tuser
//  s_*      | in  | request_size, process_id           | operation
//  m_*      | out | block_address, granted_size, id    | status
//  cfg_*    | in  | write enable, index, 16-bit value  | -
//
// A valid table entry costs a RAM read and a compare; an empty one is skipped without a read.
// Allocate runs merge passes over the free table until nothing changes and then one fit scan.
// After reset entry 0 of the free table reads as [0, total_size) without a clearing pass.
// A result waits in the output register while the next item may already be accepted.
`default_nettype none
module variable_partition_allocator
  import vpa_pkg::*;
#(
  parameter int OWNER_SLOTS = 16,
  parameter int FREE_SLOTS  = 17
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,   // request_size, process_id
  input  wire logic [0:0]  s_tuser_i,   // operation
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [47:0] m_tdata_o,   // block_address, granted_size, assigned_id
  output logic      [2:0]  m_tuser_o,   // status
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int FI = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int OI = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam logic [FI-1:0] FLAST = FI'(FREE_SLOTS - 1);
  localparam logic [OI-1:0] OLAST = OI'(OWNER_SLOTS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OS_RD = 4'd1;
  localparam logic [3:0] S_OS_WT = 4'd2;
  localparam logic [3:0] S_FH_RD = 4'd3;
  localparam logic [3:0] S_FH_WT = 4'd4;
  localparam logic [3:0] S_FH_NW = 4'd5;
  localparam logic [3:0] S_M_I   = 4'd6;
  localparam logic [3:0] S_M_IW  = 4'd7;
  localparam logic [3:0] S_M_J   = 4'd8;
  localparam logic [3:0] S_M_JW  = 4'd9;
  localparam logic [3:0] S_M_WB  = 4'd10;
  localparam logic [3:0] S_C_RD  = 4'd11;
  localparam logic [3:0] S_C_WT  = 4'd12;
  localparam logic [3:0] S_C_END = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] policy_q, policy_d;
  logic [AW-1:0] total_q, total_d, slice_q, slice_d, id_q, id_d;
  logic e0_q, e0_d, fr_init_q;
  logic [FREE_SLOTS-1:0] fvalid_q, fvalid_d;
  logic [OWNER_SLOTS-1:0] ovalid_q, ovalid_d;
  logic op_q, op_d, changed_q, changed_d, pv_q, pv_d;
  logic [AW-1:0] size_q, size_d, pid_q, pid_d, oaddr_q, oaddr_d, olen_q, olen_d;
  logic [AW-1:0] cur_s_q, cur_s_d, cur_l_q, cur_l_d, ps_q, ps_d, pl_q, pl_d;
  logic [FI-1:0] i_q, i_d, j_q, j_d, pidx_q, pidx_d;
  logic [OI-1:0] k_q, k_d, slot_q, slot_d;
  logic [2:0] st_q, st_d, mst_q, mst_d;
  logic [AW-1:0] raddr_q, raddr_d, rlen_q, rlen_d, rid_q, rid_d;
  logic [AW-1:0] maddr_q, maddr_d, mlen_q, mlen_d, mid_q, mid_d;
  logic mval_q, mval_d;

  logic fw_en, ow_en;
  logic [FI-1:0] fw_addr, fr_raddr, fe_idx;
  logic [31:0] fw_data, fr_rdata;
  logic [47:0] ow_data, or_rdata;
  logic [OI-1:0] of_idx;
  logic of_found, fe_found, take;
  logic [AW-1:0] rd_s, rd_l, f_end, o_end, cur_end, left;

  vpa_ram #(.WIDTH(32), .DEPTH(FREE_SLOTS)) u_free_ram (
    .clk_i, .we_i(fw_en), .waddr_i(fw_addr), .wdata_i(fw_data),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );

  vpa_ram #(.WIDTH(48), .DEPTH(OWNER_SLOTS)) u_owner_ram (
    .clk_i, .we_i(ow_en), .waddr_i(slot_q), .wdata_i(ow_data),
    .raddr_i(k_q), .rdata_o(or_rdata)
  );

  assign fr_raddr = (state_q == S_M_J) ? j_q : i_q;
  assign rd_s     = fr_init_q ? '0 : fr_rdata[15:0];
  assign rd_l     = fr_init_q ? total_q : fr_rdata[31:16];
  assign f_end    = rd_s + rd_l;
  assign o_end    = oaddr_q + olen_q;
  assign cur_end  = cur_s_q + cur_l_q;
  assign left     = pl_q - size_q;

  always_comb begin
    of_found = 1'b0;
    of_idx   = '0;
    for (int k = OWNER_SLOTS - 1; k >= 0; k--) begin
      if (!ovalid_q[k]) begin
        of_found = 1'b1;
        of_idx   = OI'(k);
      end
    end
    fe_found = 1'b0;
    fe_idx   = '0;
    for (int k = FREE_SLOTS - 1; k >= 0; k--) begin
      if (!fvalid_q[k]) begin
        fe_found = 1'b1;
        fe_idx   = FI'(k);
      end
    end
  end

  always_comb begin
    if (policy_q == POL_WORST) begin
      take = !pv_q || (rd_l > pl_q) || ((rd_l == pl_q) && (rd_s < ps_q));
    end else if (rd_l < size_q) begin
      take = 1'b0;
    end else if (!pv_q) begin
      take = 1'b1;
    end else if (policy_q == POL_BEST) begin
      take = (rd_l < pl_q) || ((rd_l == pl_q) && (rd_s < ps_q));
    end else begin
      take = rd_s < ps_q;
    end
  end

  always_comb begin
    state_d = state_q;  policy_d = policy_q; total_d = total_q; slice_d = slice_q;
    id_d = id_q;        e0_d = e0_q;         fvalid_d = fvalid_q; ovalid_d = ovalid_q;
    op_d = op_q;        changed_d = changed_q; pv_d = pv_q;
    size_d = size_q;    pid_d = pid_q;       oaddr_d = oaddr_q;  olen_d = olen_q;
    cur_s_d = cur_s_q;  cur_l_d = cur_l_q;   ps_d = ps_q;        pl_d = pl_q;
    i_d = i_q;          j_d = j_q;           pidx_d = pidx_q;    k_d = k_q;
    slot_d = slot_q;    st_d = st_q;         raddr_d = raddr_q;  rlen_d = rlen_q;
    rid_d = rid_q;      mst_d = mst_q;       maddr_d = maddr_q;  mlen_d = mlen_q;
    mid_d = mid_q;      mval_d = mval_q & ~m_tready_i;
    fw_en = 1'b0;       fw_addr = i_q;       fw_data = {cur_l_q, cur_s_q};
    ow_en = 1'b0;       ow_data = {AW'(0), ps_q, id_q};

    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          op_d    = s_tuser_i[0];
          size_d  = s_tdata_i[15:0];
          pid_d   = s_tdata_i[31:16];
          raddr_d = '0;
          rlen_d  = '0;
          if (s_tuser_i[0] == OP_ALLOC) begin
            id_d  = id_q + AW'(1);
            rid_d = id_q + AW'(1);
            if (s_tdata_i[15:0] == '0) begin
              st_d    = ST_BAD_SIZE;
              state_d = S_DONE;
            end else if (!of_found) begin
              st_d    = ST_FULL;
              state_d = S_DONE;
            end else begin
              slot_d    = of_idx;
              i_d       = '0;
              changed_d = 1'b0;
              state_d   = S_M_I;
            end
          end else begin
            rid_d   = '0;
            k_d     = '0;
            state_d = S_OS_RD;
          end
        end
      end
      S_OS_RD, S_OS_WT: begin
        if (state_q == S_OS_RD && ovalid_q[k_q]) begin
          state_d = S_OS_WT;
        end else if (state_q == S_OS_WT && or_rdata[15:0] == pid_q) begin
          oaddr_d = or_rdata[31:16];
          olen_d  = or_rdata[47:32];
          i_d     = '0;
          state_d = S_FH_RD;
        end else if (k_q == OLAST) begin
          st_d    = ST_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          k_d     = k_q + OI'(1);
          state_d = S_OS_RD;
        end
      end
      S_FH_RD, S_FH_WT: begin
        if (state_q == S_FH_RD && fvalid_q[i_q]) begin
          state_d = S_FH_WT;
        end else if (state_q == S_FH_WT && (f_end == oaddr_q || rd_s == o_end)) begin
          fw_en        = 1'b1;
          fw_data      = {rd_l + olen_q, (rd_s == o_end) ? oaddr_q : rd_s};
          ovalid_d[k_q] = 1'b0;
          st_d         = ST_OK;
          raddr_d      = oaddr_q;
          rlen_d       = olen_q;
          i_d          = '0;
          changed_d    = 1'b0;
          state_d      = S_M_I;
        end else if (i_q == FLAST) begin
          state_d = S_FH_NW;
        end else begin
          i_d     = i_q + FI'(1);
          state_d = S_FH_RD;
        end
      end
      S_FH_NW: begin
        if (!fe_found) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          fw_en            = 1'b1;
          fw_addr          = fe_idx;
          fw_data          = {olen_q, oaddr_q};
          fvalid_d[fe_idx] = 1'b1;
          ovalid_d[k_q]    = 1'b0;
          st_d             = ST_OK;
          raddr_d          = oaddr_q;
          rlen_d           = olen_q;
          i_d              = '0;
          changed_d        = 1'b0;
          state_d          = S_M_I;
        end
      end
      S_M_I, S_M_WB: begin
        if (state_q == S_M_I && fvalid_q[i_q]) begin
          state_d = S_M_IW;
        end else begin
          fw_en = (state_q == S_M_WB);
          if (i_q != FLAST) begin
            i_d     = i_q + FI'(1);
            state_d = S_M_I;
          end else if (changed_q) begin
            i_d       = '0;
            changed_d = 1'b0;
            state_d   = S_M_I;
          end else if (op_q == OP_ALLOC) begin
            i_d     = '0;
            pv_d    = 1'b0;
            state_d = S_C_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_M_IW: begin
        cur_s_d = rd_s;
        cur_l_d = rd_l;
        j_d     = '0;
        state_d = S_M_J;
      end
      S_M_J, S_M_JW: begin
        if (state_q == S_M_J && j_q != i_q && fvalid_q[j_q]) begin
          state_d = S_M_JW;
        end else begin
          if (state_q == S_M_JW && cur_end == rd_s) begin
            cur_l_d       = cur_l_q + rd_l;
            fvalid_d[j_q] = 1'b0;
            changed_d     = 1'b1;
          end
          if (j_q == FLAST) begin
            state_d = S_M_WB;
          end else begin
            j_d     = j_q + FI'(1);
            state_d = S_M_J;
          end
        end
      end
      S_C_RD, S_C_WT: begin
        if (state_q == S_C_RD && fvalid_q[i_q]) begin
          state_d = S_C_WT;
        end else begin
          if (state_q == S_C_WT && take) begin
            pv_d   = 1'b1;
            pidx_d = i_q;
            ps_d   = rd_s;
            pl_d   = rd_l;
          end
          if (i_q == FLAST) begin
            state_d = S_C_END;
          end else begin
            i_d     = i_q + FI'(1);
            state_d = S_C_RD;
          end
        end
      end
      S_C_END: begin
        state_d = S_DONE;
        if (!pv_q || pl_q < size_q) begin
          st_d = ST_NO_FIT;
        end else begin
          st_d    = ST_OK;
          raddr_d = ps_q;
          if (left <= slice_q) begin
            rlen_d           = pl_q;
            ow_data          = {pl_q, ps_q, id_q};
            fvalid_d[pidx_q] = 1'b0;
          end else begin
            rlen_d  = size_q;
            ow_data = {size_q, ps_q, id_q};
            fw_en   = 1'b1;
            fw_addr = pidx_q;
            fw_data = {left, ps_q + size_q};
          end
          ow_en            = 1'b1;
          ovalid_d[slot_q] = 1'b1;
        end
      end
      S_DONE: begin
        if (!mval_q || m_tready_i) begin
          mval_d  = 1'b1;
          mst_d   = st_q;
          maddr_d = raddr_q;
          mlen_d  = rlen_q;
          mid_d   = rid_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fw_en && fw_addr == '0) begin
      e0_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLICY: policy_d = cfg_data_i[1:0];
        CFG_TOTAL: begin
          total_d     = cfg_data_i;
          e0_d        = 1'b1;
          fvalid_d    = '0;
          fvalid_d[0] = (cfg_data_i != '0);
          ovalid_d    = '0;
        end
        CFG_SLICE: slice_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      policy_q  <= POL_FIRST;
      total_q   <= TOTAL_RESET;
      slice_q   <= SLICE_RESET;
      id_q      <= '0;
      e0_q      <= 1'b1;
      fr_init_q <= 1'b0;
      fvalid_q  <= FREE_SLOTS'(1);
      ovalid_q  <= '0;
      mval_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      policy_q  <= policy_d;
      total_q   <= total_d;
      slice_q   <= slice_d;
      id_q      <= id_d;
      e0_q      <= e0_d;
      fr_init_q <= e0_q && (fr_raddr == '0);
      fvalid_q  <= fvalid_d;
      ovalid_q  <= ovalid_d;
      mval_q    <= mval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;       changed_q <= changed_d; pv_q <= pv_d;
    size_q <= size_d;   pid_q <= pid_d;         oaddr_q <= oaddr_d; olen_q <= olen_d;
    cur_s_q <= cur_s_d; cur_l_q <= cur_l_d;     ps_q <= ps_d;       pl_q <= pl_d;
    i_q <= i_d;         j_q <= j_d;             pidx_q <= pidx_d;   k_q <= k_d;
    slot_q <= slot_d;   st_q <= st_d;           raddr_q <= raddr_d; rlen_q <= rlen_d;
    rid_q <= rid_d;     mst_q <= mst_d;         maddr_q <= maddr_d; mlen_q <= mlen_d;
    mid_q <= mid_d;
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = mval_q;
  assign m_tdata_o  = {mid_q, mlen_q, maddr_q};
  assign m_tuser_o  = mst_q;
endmodule
`default_nettype wire

// ===== design/vpa_checker.sv =====
// Port-level checker for the variable partition allocator, bound to the top level.
// Depends on vpa_pkg.
`default_nettype none
module vpa_checker
  import vpa_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid_i,
  input wire logic        s_tready_o,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [47:0] m_tdata_o,
  input wire logic [2:0]  m_tuser_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("stalled result item changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("accepted a second item without working on the first");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o != ST_OK |-> m_tdata_o[31:0] == '0)
    else $error("error result carries an address or size");

  a_nf_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o == ST_NOT_FOUND |-> m_tdata_o[47:32] == '0)
    else $error("free result carries an id");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tuser_o <= ST_FULL)
    else $error("status code out of range");
endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (.*);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for variable_partition_allocator: it runs directed and random allocate
// and free requests under all fit policies, with varied range sizes, slice limits and idling.
// Depends on vpa_pkg and the allocator RTL.
module tb;
  import vpa_pkg::*;

  localparam int NOWN = 16;
  localparam int NFREE = 17;
  localparam longint LIMIT = 12000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] addr;
    logic [15:0] len;
    logic [15:0] id;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  variable_partition_allocator uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata), .m_tuser_o(m_tuser),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [1:0]  mdl_policy;
  logic [15:0] mdl_total, mdl_slice, mdl_counter;
  logic [15:0] fr_start[NFREE], fr_len[NFREE];
  bit          fr_valid[NFREE];
  logic [15:0] own_id[NOWN], own_start[NOWN], own_len[NOWN];
  bit          own_valid[NOWN];

  grant_t      pending_grants[$];
  logic [15:0] live_ids[$];
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          mismatches = 0;
  longint      cycles = 0;

  function automatic void clear_tables();
    for (int i = 0; i < NFREE; i++) fr_valid[i] = 0;
    for (int k = 0; k < NOWN; k++) own_valid[k] = 0;
    if (mdl_total != 0) begin
      fr_start[0] = '0;
      fr_len[0] = mdl_total;
      fr_valid[0] = 1;
    end
    live_ids.delete();
  endfunction

  function automatic void coalesce_free();
    bit changed;
    logic [15:0] e;
    changed = 1;
    while (changed) begin
      changed = 0;
      for (int i = 0; i < NFREE; i++) begin
        if (!fr_valid[i]) continue;
        for (int j = 0; j < NFREE; j++) begin
          if (j == i || !fr_valid[j]) continue;
          e = fr_start[i] + fr_len[i];
          if (e == fr_start[j]) begin
            fr_len[i] = fr_len[i] + fr_len[j];
            fr_valid[j] = 0;
            changed = 1;
          end
        end
      end
    end
  endfunction

  function automatic int pick_block(logic [15:0] size);
    int p;
    p = -1;
    for (int i = 0; i < NFREE; i++) begin
      if (!fr_valid[i]) continue;
      if (mdl_policy == POL_WORST) begin
        if (p < 0 || fr_len[i] > fr_len[p] ||
            (fr_len[i] == fr_len[p] && fr_start[i] < fr_start[p])) p = i;
        continue;
      end
      if (fr_len[i] < size) continue;
      if (p < 0) p = i;
      else if (mdl_policy == POL_BEST) begin
        if (fr_len[i] < fr_len[p] || (fr_len[i] == fr_len[p] && fr_start[i] < fr_start[p]))
          p = i;
      end else if (fr_start[i] < fr_start[p]) p = i;
    end
    if (p >= 0 && fr_len[p] < size) p = -1;
    return p;
  endfunction

  function automatic grant_t predict_grant(logic op, logic [15:0] size, logic [15:0] pid);
    grant_t g;
    int slot, b, o, hit, e;
    logic [15:0] a, l, fin, sum;
    g = '0;
    if (op == OP_ALLOC) begin
      mdl_counter = mdl_counter + 16'd1;
      g.id = mdl_counter;
      if (size == 0) begin
        g.status = ST_BAD_SIZE;
        return g;
      end
      slot = -1;
      for (int k = 0; k < NOWN; k++) if (!own_valid[k] && slot < 0) slot = k;
      if (slot < 0) begin
        g.status = ST_FULL;
        return g;
      end
      coalesce_free();
      b = pick_block(size);
      if (b < 0) begin
        g.status = ST_NO_FIT;
        return g;
      end
      a = fr_start[b];
      if (fr_len[b] - size <= mdl_slice) begin
        l = fr_len[b];
        fr_valid[b] = 0;
      end else begin
        l = size;
        fr_start[b] = fr_start[b] + size;
        fr_len[b] = fr_len[b] - size;
      end
      own_valid[slot] = 1;
      own_id[slot] = g.id;
      own_start[slot] = a;
      own_len[slot] = l;
      live_ids.push_back(g.id);
      g.status = ST_OK;
      g.addr = a;
      g.len = l;
      return g;
    end
    o = -1;
    for (int k = 0; k < NOWN; k++) if (o < 0 && own_valid[k] && own_id[k] == pid) o = k;
    if (o < 0) begin
      g.status = ST_NOT_FOUND;
      return g;
    end
    a = own_start[o];
    l = own_len[o];
    fin = a + l;
    hit = -1;
    for (int i = 0; i < NFREE; i++) begin
      if (!fr_valid[i] || hit >= 0) continue;
      sum = fr_start[i] + fr_len[i];
      if (sum == a || fr_start[i] == fin) hit = i;
    end
    if (hit >= 0) begin
      if (fr_start[hit] == fin) fr_start[hit] = a;
      fr_len[hit] = fr_len[hit] + l;
    end else begin
      e = -1;
      for (int i = 0; i < NFREE; i++) if (e < 0 && !fr_valid[i]) e = i;
      if (e < 0) begin
        g.status = ST_FULL;
        return g;
      end
      fr_valid[e] = 1;
      fr_start[e] = a;
      fr_len[e] = l;
    end
    own_valid[o] = 0;
    foreach (live_ids[q]) if (live_ids[q] == pid) begin
      live_ids.delete(q);
      break;
    end
    coalesce_free();
    g.status = ST_OK;
    g.addr = a;
    g.len = l;
    return g;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= rcv_stall_pct);

  always @(posedge clk) begin
    grant_t got, want;
    if (rst_n && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]};
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_grants.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic send_request(logic op, logic [15:0] size, logic [15:0] pid);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {pid, size};
    do @(posedge clk); while (!s_tready);
    pending_grants.push_back(predict_grant(op, size, pid));
  endtask

  task automatic drain();
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) mdl_policy = val[1:0];
    else if (idx == CFG_TOTAL) begin
      mdl_total = val;
      clear_tables();
    end else if (idx == CFG_SLICE) mdl_slice = val;
  endtask

  task automatic random_free();
    logic [15:0] pid;
    if (live_ids.size() != 0 && $urandom_range(9) != 0)
      pid = live_ids[$urandom_range(live_ids.size() - 1)];
    else pid = 16'($urandom);
    send_request(OP_FREE, 16'($urandom), pid);
  endtask

  task automatic random_alloc();
    logic [15:0] size;
    int r;
    r = $urandom_range(99);
    if (r < 4) size = 0;
    else if (r < 10) size = 16'($urandom);
    else size = 16'($urandom_range((mdl_total > 48) ? mdl_total / 6 : 8, 1));
    send_request(OP_ALLOC, size, 16'($urandom));
  endtask

  task automatic test_directed();
    send_request(OP_ALLOC, 16'd0, 16'hFFFF);
    send_request(OP_ALLOC, 16'hFFFF, 16'd0);
    send_request(OP_FREE, 16'd0, 16'hABCD);
    for (int i = 0; i < 16; i++) send_request(OP_ALLOC, 16'(40 + i), 16'd0);
    send_request(OP_ALLOC, 16'd5, 16'd0);
    send_request(OP_FREE, 16'hFFFF, 16'd2);
    send_request(OP_FREE, 16'd0, 16'd4);
    send_request(OP_FREE, 16'd0, 16'd3);
    send_request(OP_ALLOC, 16'd30, 16'd0);
    send_request(OP_FREE, 16'd0, 16'd3);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55 && live_ids.size() < 14) random_alloc();
      else random_free();
    end
  endtask

  task automatic test_settings(logic [1:0] pol, logic [15:0] tot, logic [15:0] sl, int n);
    write_reg(CFG_POLICY, {14'd0, pol});
    write_reg(CFG_SLICE, sl);
    write_reg(CFG_TOTAL, tot);
    test_random(n);
  endtask

  task automatic test_pause();
    test_random(20);
    drain();
    test_random(20);
  endtask

  initial begin
    mdl_policy = POL_FIRST;
    mdl_total = TOTAL_RESET;
    mdl_slice = SLICE_RESET;
    mdl_counter = '0;
    clear_tables();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_reg(CFG_POLICY, {14'd0, POL_WORST});
    test_directed();
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 34 : 0;
      rcv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 34 : 0;
      test_settings(POL_FIRST, 16'd1024, 16'd10, 60);
      test_settings(POL_BEST, 16'd300, 16'd0, 60);
      test_settings(POL_WORST, 16'hFFFF, 16'hFFFF, 25);
      test_settings(2'd3, 16'd200, 16'd3, 40);
      test_settings(POL_BEST, 16'd1, 16'd0, 10);
      test_settings(POL_WORST, 16'd0, 16'd10, 8);
      test_settings(POL_WORST, 16'd700, 16'd2, 50);
      test_pause();
    end
    drain();
    repeat (3000) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vpa_pkg.sv
design/vpa_ram.sv
design/variable_partition_allocator.sv
design/vpa_checker.sv
sim/tb.sv
